[sv/kst_pkg.sv]
// Shared types and constants for the shared free-list stack block.
package kst_pkg;

    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int SN_W     = 2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [STATUS_W-1:0]      t_status;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam t_status STAT_DONE  = 2'd0;
    localparam t_status STAT_FULL  = 2'd1;
    localparam t_status STAT_EMPTY = 2'd2;

    localparam t_word MOST_NEG_WORD = 32'sh8000_0000;

endpackage

[sv/kst_slot_mem.sv]
// Slot memory: one entry per store slot holding {link, word}, registered read.
module kst_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 37
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/kst_head_mem.sv]
// Stack head memory with per-stack valid bits; an unwritten head reads as none.
module kst_head_mem #(
    parameter int COUNT = 4,
    parameter int SW    = 2,
    parameter int PW    = 5,
    parameter int NONE  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [SW-1:0] i_waddr,
    input  logic [PW-1:0] i_wdata,
    input  logic [SW-1:0] i_raddr,
    output logic [PW-1:0] o_rdata
);

    logic [PW-1:0]    r_mem [COUNT];
    logic [PW-1:0]    r_rdata;
    logic [COUNT-1:0] r_vld;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    // An entry never written holds an empty stack.
    assign o_rdata = r_rd_vld ? r_rdata : PW'(NONE);

endmodule

[sv/k_stacks_shared_free_list_top.sv]
// Top level: several LIFO stacks sharing one slot store through a linked free list.
// A push passes through S_HEAD, a pop through S_HEAD and, unless refused, S_POP.
// A new command is taken only once the last result is out; a pop must read the
//   head memory before it can address the slot memory, and each memory has one read port.
// Reset: synchronous active low; all stacks empty, free list at slot 0, no clearing pass.
// The receiver cannot stall: each result is presented for exactly one cycle.
module k_stacks_shared_free_list_top #(
    parameter int STORE_DEPTH = 16,
    parameter int STACK_COUNT = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_op,
    input  logic [kst_pkg::SN_W-1:0]           i_stack_number,
    input  logic signed [kst_pkg::WORD_W-1:0]  i_push_data,
    output logic                               o_valid,
    output logic signed [kst_pkg::WORD_W-1:0]  o_pop_data,
    output logic [kst_pkg::STATUS_W-1:0]       o_status,
    output logic [kst_pkg::OCC_W-1:0]          o_occupancy
);

    // Pointer width holds every slot index plus the "none" code (STORE_DEPTH).
    localparam int PW   = $clog2(STORE_DEPTH + 1);
    localparam int SAW  = $clog2(STORE_DEPTH);
    localparam int SW   = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
    localparam int CW   = (PW > kst_pkg::OCC_W) ? PW : kst_pkg::OCC_W;
    localparam int DW   = PW + kst_pkg::WORD_W;
    localparam logic [PW-1:0] NONE = PW'(STORE_DEPTH);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;  // wait for a command
    localparam logic [1:0] S_HEAD = 2'd1;  // head and free-slot reads are back
    localparam logic [1:0] S_POP  = 2'd2;  // popped slot read is back

    logic [1:0]    r_state, n_state;
    logic [PW-1:0] r_free, n_free;     // head of free list
    logic [PW-1:0] r_fresh, n_fresh;   // slots below this have had their link written
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_slot, n_slot;     // slot being popped

    // Latched command.
    logic                  r_op;
    logic                  r_sn_ok;
    logic [SW-1:0]         r_sn_idx;
    kst_pkg::t_word        r_data;

    // Result registers.
    logic                  r_valid, n_valid;
    kst_pkg::t_word        r_pop_data, n_pop_data;
    kst_pkg::t_status      r_status, n_status;
    logic [kst_pkg::OCC_W-1:0] r_occ, n_occ;

    // Memory ports.
    logic           w_accept;
    logic [31:0]    w_sn_wide;
    logic [SW-1:0]  w_sn_idx;
    logic           w_sn_ok;
    logic [PW-1:0]  w_head_rd;
    logic           w_head_we;
    logic [PW-1:0]  w_head_wdata;
    logic [DW-1:0]  w_slot_rd;
    logic [PW-1:0]  w_slot_link;
    kst_pkg::t_word w_slot_word;
    logic           w_slot_we;
    logic [SAW-1:0] w_slot_waddr;
    logic [DW-1:0]  w_slot_wdata;
    logic [SAW-1:0] w_slot_raddr;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_sn_wide = 32'(i_stack_number);
    assign w_sn_idx  = w_sn_wide[SW-1:0];
    assign w_sn_ok   = (w_sn_wide < 32'(STACK_COUNT));

    assign w_slot_link = w_slot_rd[kst_pkg::WORD_W +: PW];
    assign w_slot_word = w_slot_rd[kst_pkg::WORD_W-1:0];

    // Address the popped slot once its head is known, else the free-list head.
    assign w_slot_raddr = (r_state == S_HEAD) ? w_head_rd[SAW-1:0] : r_free[SAW-1:0];

    kst_head_mem #(
        .COUNT (STACK_COUNT),
        .SW    (SW),
        .PW    (PW),
        .NONE  (STORE_DEPTH)
    ) u_head_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_head_we),
        .i_waddr (r_sn_idx),
        .i_wdata (w_head_wdata),
        .i_raddr (w_sn_idx),
        .o_rdata (w_head_rd)
    );

    kst_slot_mem #(
        .DEPTH (STORE_DEPTH),
        .AW    (SAW),
        .DW    (DW)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_slot_wdata),
        .i_raddr (w_slot_raddr),
        .o_rdata (w_slot_rd)
    );

    always_comb begin
        n_state      = r_state;
        n_free       = r_free;
        n_fresh      = r_fresh;
        n_count      = r_count;
        n_slot       = r_slot;
        n_valid      = 1'b0;
        n_pop_data   = r_pop_data;
        n_status     = r_status;
        n_occ        = r_occ;
        w_head_we    = 1'b0;
        w_head_wdata = w_slot_link;
        w_slot_we    = 1'b0;
        w_slot_waddr = r_free[SAW-1:0];
        w_slot_wdata = {w_head_rd, r_data};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (r_op == kst_pkg::OP_PUSH) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_pop_data = '0;
                    if (!r_sn_ok || r_free == NONE) begin
                        // Refuse: store full or no such stack.
                        n_status = kst_pkg::STAT_FULL;
                    end else begin
                        // Link the free slot onto the stack head and advance the free list.
                        w_slot_we    = 1'b1;
                        w_slot_waddr = r_free[SAW-1:0];
                        w_slot_wdata = {w_head_rd, r_data};
                        w_head_we    = 1'b1;
                        w_head_wdata = r_free;
                        if (r_free == r_fresh) begin
                            // Never-linked slot: its link is the next slot index.
                            n_free  = r_free + PW'(1);
                            n_fresh = r_fresh + PW'(1);
                        end else begin
                            n_free = w_slot_link;
                        end
                        n_count  = r_count + CW'(1);
                        n_status = kst_pkg::STAT_DONE;
                    end
                    n_occ = n_count[kst_pkg::OCC_W-1:0];
                end else begin
                    if (!r_sn_ok || w_head_rd == NONE) begin
                        n_state    = S_IDLE;
                        n_valid    = 1'b1;
                        n_pop_data = kst_pkg::MOST_NEG_WORD;
                        n_status   = kst_pkg::STAT_EMPTY;
                        n_occ      = r_count[kst_pkg::OCC_W-1:0];
                    end else begin
                        // Hold the head slot while its entry is read.
                        n_slot  = w_head_rd;
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                // Unlink the head, return the slot to the free list.
                w_head_we    = 1'b1;
                w_head_wdata = w_slot_link;
                w_slot_we    = 1'b1;
                w_slot_waddr = r_slot[SAW-1:0];
                w_slot_wdata = {r_free, w_slot_word};
                n_free       = r_slot;
                if (r_count != '0) begin
                    n_count = r_count - CW'(1);
                end
                n_state    = S_IDLE;
                n_valid    = 1'b1;
                n_pop_data = w_slot_word;
                n_status   = kst_pkg::STAT_DONE;
                n_occ      = n_count[kst_pkg::OCC_W-1:0];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= '0;
            r_fresh <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_fresh <= n_fresh;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_op;
            r_sn_ok  <= w_sn_ok;
            r_sn_idx <= w_sn_idx;
            r_data   <= i_push_data;
        end
        r_slot     <= n_slot;
        r_pop_data <= n_pop_data;
        r_status   <= n_status;
        r_occ      <= n_occ;
    end

    assign o_valid     = r_valid;
    assign o_pop_data  = r_pop_data;
    assign o_status    = r_status;
    assign o_occupancy = r_occ;

    // Stored words never exceed the store.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STORE_DEPTH))
        else $error("word count above store depth");

    // The free list is empty exactly when every slot holds a word.
    a_full_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == NONE) == (r_count == CW'(STORE_DEPTH)))
        else $error("free list and word count disagree");

    // A result strobe always lands with the sequencer back at rest.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted command always occupies the sequencer on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted command did not start");

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Testbench for the shared free-list stack block: directed table, then biased random traffic.
module tb;

    localparam int DEPTH  = 16;
    localparam int NSTACK = 4;
    localparam logic [4:0] SLOT_NONE = 5'(DEPTH);

    typedef struct packed {
        kst_pkg::t_word            pop_word;
        kst_pkg::t_status          st;
        logic [kst_pkg::OCC_W-1:0] occ;
    } t_stack_reply;

    typedef struct packed {
        logic                     op;
        logic [kst_pkg::SN_W-1:0] sn;
        kst_pkg::t_word           data;
        logic                     typed;
        t_stack_reply             reply;
    } t_plan_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_op = kst_pkg::OP_PUSH;
    logic [kst_pkg::SN_W-1:0]  i_stack_number = '0;
    kst_pkg::t_word            i_push_data = '0;
    logic                      o_valid;
    kst_pkg::t_word            o_pop_data;
    kst_pkg::t_status          o_status;
    logic [kst_pkg::OCC_W-1:0] o_occupancy;

    // Shadow copy of the store, the links, the stack tops and the free list.
    kst_pkg::t_word       word_slots [DEPTH];
    logic [4:0]           next_slot  [DEPTH];
    logic [4:0]           top_slot   [NSTACK];
    logic [4:0]           free_top;
    int                   words_held;

    t_stack_reply         awaited_replies[$];
    t_plan_row            plan[$];
    int                   mismatches = 0;

    k_stacks_shared_free_list_top #(
        .STORE_DEPTH(DEPTH),
        .STACK_COUNT(NSTACK)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_stack_number(i_stack_number),
        .i_push_data(i_push_data),
        .o_valid(o_valid),
        .o_pop_data(o_pop_data),
        .o_status(o_status),
        .o_occupancy(o_occupancy)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Apply one request to the shadow state and return the reply it must produce.
    function automatic t_stack_reply predict_stack_reply(logic op,
                                                         logic [kst_pkg::SN_W-1:0] sn,
                                                         kst_pkg::t_word data);
        t_stack_reply r;
        logic [4:0]   slot;
        r.pop_word = '0;
        r.st       = kst_pkg::STAT_DONE;
        if (op == kst_pkg::OP_PUSH) begin
            slot = free_top;
            if (int'(sn) >= NSTACK || slot >= SLOT_NONE) begin
                r.st = kst_pkg::STAT_FULL;
            end else begin
                word_slots[slot] = data;
                free_top         = next_slot[slot];
                next_slot[slot]  = top_slot[sn];
                top_slot[sn]     = slot;
                words_held++;
            end
        end else begin
            if (int'(sn) >= NSTACK || top_slot[sn] >= SLOT_NONE) begin
                r.pop_word = kst_pkg::MOST_NEG_WORD;
                r.st       = kst_pkg::STAT_EMPTY;
            end else begin
                slot            = top_slot[sn];
                r.pop_word      = word_slots[slot];
                top_slot[sn]    = next_slot[slot];
                next_slot[slot] = free_top;
                free_top        = slot;
                if (words_held > 0)
                    words_held--;
            end
        end
        r.occ = words_held[kst_pkg::OCC_W-1:0];
        return r;
    endfunction

    function automatic t_plan_row make_row(logic op, logic [kst_pkg::SN_W-1:0] sn,
                                           kst_pkg::t_word data, logic typed,
                                           kst_pkg::t_word w, kst_pkg::t_status st,
                                           int occ);
        t_plan_row row;
        row.op             = op;
        row.sn             = sn;
        row.data           = data;
        row.typed          = typed;
        row.reply.pop_word = w;
        row.reply.st       = st;
        row.reply.occ      = kst_pkg::OCC_W'(occ);
        return row;
    endfunction

    // Present one transaction from a falling edge, hold it until accepted, then
    // record the reply it must produce. Start stays high for a following request.
    task automatic issue_request(logic op, logic [kst_pkg::SN_W-1:0] sn,
                                 kst_pkg::t_word data, logic typed,
                                 t_stack_reply typed_reply);
        t_stack_reply predicted;
        start          = 1'b1;
        i_op           = op;
        i_stack_number = sn;
        i_push_data    = data;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predicted = predict_stack_reply(op, sn, data);
        awaited_replies.push_back(typed ? typed_reply : predicted);
        @(negedge i_clk);
    endtask

    // Drop start for a few cycles; scramble the payload so it is seen as ignored.
    task automatic idle_cycles(int n);
        start          = 1'b0;
        i_op           = 1'($urandom);
        i_stack_number = kst_pkg::SN_W'($urandom);
        i_push_data    = kst_pkg::t_word'($urandom);
        repeat (n) @(negedge i_clk);
    endtask

    // Check every result strobe against the oldest awaited reply.
    always @(posedge i_clk) begin
        t_stack_reply exp_r;
        if (i_rst_n && o_valid) begin
            if (awaited_replies.size() == 0) begin
                $error("unexpected result: pop_data %0d status %0d occupancy %0d",
                       o_pop_data, o_status, o_occupancy);
                mismatches++;
            end else begin
                exp_r = awaited_replies.pop_front();
                if (o_pop_data !== exp_r.pop_word) begin
                    $error("pop_data expected %0d actual %0d", exp_r.pop_word, o_pop_data);
                    mismatches++;
                end
                if (o_status !== exp_r.st) begin
                    $error("status expected %0d actual %0d", exp_r.st, o_status);
                    mismatches++;
                end
                if (o_occupancy !== exp_r.occ) begin
                    $error("occupancy expected %0d actual %0d", exp_r.occ, o_occupancy);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("k_stacks_shared_free_list_top test failed");
        $finish;
    end

    initial begin
        int              idle_pct;
        int              push_pct;
        logic            op;
        kst_pkg::t_word  d;
        kst_pkg::t_word  extremes [4];
        extremes = '{kst_pkg::MOST_NEG_WORD, 32'sh7fff_ffff, 32'sh0, -32'sd1};

        for (int k = 0; k < DEPTH; k++) begin
            word_slots[k] = '0;
            next_slot[k]  = 5'(k + 1);
        end
        for (int k = 0; k < NSTACK; k++)
            top_slot[k] = SLOT_NONE;
        free_top   = '0;
        words_held = 0;

        // Directed table: empty pops, extreme words through every stack, fill to
        // the brim, one refused push, then one pop and a push back.
        plan.push_back(make_row(kst_pkg::OP_POP,  2'd0, 32'sh1234_5678, 1'b1,
                                kst_pkg::MOST_NEG_WORD, kst_pkg::STAT_EMPTY, 0));
        plan.push_back(make_row(kst_pkg::OP_POP,  2'd3, 32'sh0,         1'b1,
                                kst_pkg::MOST_NEG_WORD, kst_pkg::STAT_EMPTY, 0));
        plan.push_back(make_row(kst_pkg::OP_PUSH, 2'd0, 32'sh7fff_ffff, 1'b1,
                                32'sh0, kst_pkg::STAT_DONE, 1));
        plan.push_back(make_row(kst_pkg::OP_PUSH, 2'd1, kst_pkg::MOST_NEG_WORD, 1'b1,
                                32'sh0, kst_pkg::STAT_DONE, 2));
        plan.push_back(make_row(kst_pkg::OP_PUSH, 2'd2, 32'sh0,         1'b1,
                                32'sh0, kst_pkg::STAT_DONE, 3));
        plan.push_back(make_row(kst_pkg::OP_PUSH, 2'd3, -32'sd1,        1'b1,
                                32'sh0, kst_pkg::STAT_DONE, 4));
        // a popped most negative word still reports done
        plan.push_back(make_row(kst_pkg::OP_POP,  2'd1, 32'sh0,         1'b1,
                                kst_pkg::MOST_NEG_WORD, kst_pkg::STAT_DONE, 3));
        plan.push_back(make_row(kst_pkg::OP_POP,  2'd3, 32'sh0,         1'b1,
                                -32'sd1, kst_pkg::STAT_DONE, 2));
        for (int k = 0; k < DEPTH - 2; k++)
            plan.push_back(make_row(kst_pkg::OP_PUSH, kst_pkg::SN_W'(k),
                                    {16'(k * 4099), ~16'(k * 7)},
                                    1'b0, '0, kst_pkg::STAT_DONE, 0));
        // store full: refused and nothing changes
        plan.push_back(make_row(kst_pkg::OP_PUSH, 2'd2, 32'sh5555_aaaa, 1'b1,
                                32'sh0, kst_pkg::STAT_FULL, 16));
        plan.push_back(make_row(kst_pkg::OP_POP,  2'd0, 32'sh0,         1'b0,
                                '0, kst_pkg::STAT_DONE, 0));
        plan.push_back(make_row(kst_pkg::OP_PUSH, 2'd0, 32'shaaaa_5555, 1'b0,
                                '0, kst_pkg::STAT_DONE, 0));

        // Hold reset, then release it on a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (plan[k])
            issue_request(plan[k].op, plan[k].sn, plan[k].data, plan[k].typed, plan[k].reply);

        // Random traffic in three phases, the last without idle gaps. Alternate push-heavy and pop-heavy
        // windows so the store keeps swinging between full and empty.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 31 : (phase == 1) ? 49 : 0;
            for (int n = 0; n < 610; n++) begin
                push_pct = ((n / 48) % 2 == 0) ? 72 : 28;
                op = ($urandom_range(99) < push_pct) ? kst_pkg::OP_PUSH : kst_pkg::OP_POP;
                d  = ($urandom_range(19) == 0) ? extremes[$urandom_range(3)]
                                               : kst_pkg::t_word'($urandom);
                if ($urandom_range(99) < idle_pct)
                    idle_cycles($urandom_range(1, 4));
                issue_request(op, kst_pkg::SN_W'($urandom_range(NSTACK - 1)), d, 1'b0, '0);
            end
            // After the first phase only, pause until every awaited reply is back.
            if (phase == 0) begin
                start = 1'b0;
                while (awaited_replies.size() != 0)
                    @(negedge i_clk);
            end
        end

        // Drain, then allow a few cycles for any stray strobe.
        start = 1'b0;
        while (awaited_replies.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatches == 0)
            $display("k_stacks_shared_free_list_top test passed");
        else
            $display("k_stacks_shared_free_list_top test failed");
        $finish;
    end

endmodule

[files.f]
sv/kst_pkg.sv
sv/kst_slot_mem.sv
sv/kst_head_mem.sv
sv/k_stacks_shared_free_list_top.sv
test/tb.sv
